// ----- rtl/lobl_pkg.sv -----
// Shared types and constants for the limited-depth order book.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps

package lobl_pkg;

  localparam int BOOK_DEPTH = 10;
  localparam int PRICE_W    = 32;
  localparam int QTY_W      = 32;
  localparam int LIDX_W     = 4;
  localparam int POS_W      = 4;
  localparam int ACT_W      = 3;
  localparam int IDX_W      = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CMP_W      = (IDX_W > LIDX_W) ? IDX_W : LIDX_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE   = 3'd0,
    ACT_UPDATE = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_LOAD   = 3'd4
  } action_e;

  // One request as seen by the cells of one side.
  typedef struct packed {
    logic               is_load;
    logic               is_bid;
    logic [CMP_W-1:0]   index;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } lobl_req_t;

  // Passed from cell to cell: whether an earlier slot already took the request.
  typedef struct packed {
    logic             found;
    action_e          act;
    logic [IDX_W-1:0] pos;
  } lobl_chain_t;

endpackage

// ----- rtl/lobl_cell.sv -----
// One slot of one book side: holds a price and quantity level.
// Depends on lobl_pkg; instantiated in a row by lobl_side.
`timescale 1ns / 1ps

module lobl_cell
  import lobl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  lobl_req_t          req_i,
  input  logic [IDX_W-1:0]   slot_i,
  input  logic [PRICE_W-1:0] left_price_i,
  input  logic [QTY_W-1:0]   left_qty_i,
  input  logic [PRICE_W-1:0] right_price_i,
  input  logic [QTY_W-1:0]   right_qty_i,
  input  lobl_chain_t        chain_i,
  output lobl_chain_t        chain_o,
  output logic [PRICE_W-1:0] price_o,
  output logic [QTY_W-1:0]   qty_o,
  output logic [PRICE_W-1:0] next_price_o,
  output logic [QTY_W-1:0]   next_qty_o
);

  logic [PRICE_W-1:0] price_q, price_d;
  logic [QTY_W-1:0]   qty_q, qty_d;
  logic               eq, better, active, first, load_here;
  action_e            kind;

  always_comb begin
    eq        = (req_i.price == price_q);
    better    = req_i.is_bid ? (req_i.price > price_q) : (req_i.price < price_q);
    active    = en_i && !req_i.is_load && (req_i.price != '0);
    first     = active && !chain_i.found &&
                (eq || ((req_i.qty != '0) && (better || (price_q == '0))));
    load_here = en_i && req_i.is_load && (req_i.index == CMP_W'(slot_i));
    if (eq) begin
      kind = (req_i.qty == '0) ? ACT_REMOVE : ACT_UPDATE;
    end else begin
      kind = ACT_INSERT;
    end
  end

  always_comb begin
    price_d = price_q;
    qty_d   = qty_q;
    if (load_here) begin
      price_d = req_i.price;
      qty_d   = (req_i.price == '0) ? '0 : req_i.qty;
    end else if (first) begin
      unique case (kind)
        ACT_REMOVE: begin
          price_d = right_price_i;
          qty_d   = right_qty_i;
        end
        ACT_UPDATE: begin
          qty_d = req_i.qty;
        end
        default: begin
          price_d = req_i.price;
          qty_d   = req_i.qty;
        end
      endcase
    end else if (active && chain_i.found) begin
      // Slots behind the affected one move up on a remove, down on an insert.
      if (chain_i.act == ACT_REMOVE) begin
        price_d = right_price_i;
        qty_d   = right_qty_i;
      end else if (chain_i.act == ACT_INSERT) begin
        price_d = left_price_i;
        qty_d   = left_qty_i;
      end
    end
  end

  always_comb begin
    chain_o = chain_i;
    if (first) begin
      chain_o.found = 1'b1;
      chain_o.act   = kind;
      chain_o.pos   = slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      price_q <= '0;
      qty_q   <= '0;
    end else begin
      price_q <= price_d;
      qty_q   <= qty_d;
    end
  end

  assign price_o      = price_q;
  assign qty_o        = qty_q;
  assign next_price_o = price_d;
  assign next_qty_o   = qty_d;

endmodule

// ----- rtl/lobl_side.sv -----
// One side of the book: a row of BOOK_DEPTH slot cells, best level first.
// Depends on lobl_pkg and lobl_cell.
`timescale 1ns / 1ps

module lobl_side
  import lobl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  lobl_req_t          req_i,
  output lobl_chain_t        chain_o,
  output logic [PRICE_W-1:0] best_price_o,
  output logic [QTY_W-1:0]   best_qty_o
);

  logic [PRICE_W-1:0] cur_price [BOOK_DEPTH];
  logic [QTY_W-1:0]   cur_qty   [BOOK_DEPTH];
  logic [PRICE_W-1:0] nxt_price [BOOK_DEPTH];
  logic [QTY_W-1:0]   nxt_qty   [BOOK_DEPTH];
  lobl_chain_t        chain     [BOOK_DEPTH+1];

  assign chain[0] = '{found: 1'b0, act: ACT_NONE, pos: '0};

  for (genvar k = 0; k < BOOK_DEPTH; k++) begin : g_cell
    logic [PRICE_W-1:0] lp, rp;
    logic [QTY_W-1:0]   lq, rq;

    if (k == 0) begin : g_head
      assign lp = '0;
      assign lq = '0;
    end else begin : g_body
      assign lp = cur_price[k-1];
      assign lq = cur_qty[k-1];
    end

    // The last slot empties when a level is removed ahead of it.
    if (k == BOOK_DEPTH - 1) begin : g_tail
      assign rp = '0;
      assign rq = '0;
    end else begin : g_mid
      assign rp = cur_price[k+1];
      assign rq = cur_qty[k+1];
    end

    lobl_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (en_i),
      .req_i         (req_i),
      .slot_i        (IDX_W'(k)),
      .left_price_i  (lp),
      .left_qty_i    (lq),
      .right_price_i (rp),
      .right_qty_i   (rq),
      .chain_i       (chain[k]),
      .chain_o       (chain[k+1]),
      .price_o       (cur_price[k]),
      .qty_o         (cur_qty[k]),
      .next_price_o  (nxt_price[k]),
      .next_qty_o    (nxt_qty[k])
    );
  end

  assign chain_o      = chain[BOOK_DEPTH];
  assign best_price_o = nxt_price[0];
  assign best_qty_o   = nxt_qty[0];

endmodule

// ----- rtl/limit_order_book_level_update.sv -----
// Top level of the limited-depth order book: two slot rows and a result register.
// Depends on lobl_pkg and lobl_side.
`timescale 1ns / 1ps

// Usage:
// A request is taken on the input channel when in_valid_i is high and in_stall_o
// is low. req_type_i selects a level update (0) or a snapshot load at
// level_index_i (1); side_i selects asks (0) or bids (1).
// Each request yields exactly one result on the output channel, taken when
// out_valid_o is high and out_stall_i is low. The result carries the action,
// the affected slot and both best levels after the request.
// The result is registered and appears in the cycle after acceptance.
// Throughput is one request per cycle while no result is stalled; the whole
// side is compared and shifted in that cycle by the row of slot cells, each
// taking its neighbor's level. While a result is held by a stalled receiver,
// in_stall_o is high and no request is taken; when the result leaves, a new
// request is taken in the same cycle. Reset empties both sides at once (all
// prices and quantities zero) and drops any pending result.

module limit_order_book_level_update
  import lobl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic               side_i,
  input  logic [LIDX_W-1:0]  level_index_i,
  input  logic [PRICE_W-1:0] level_price_i,
  input  logic [QTY_W-1:0]   level_quantity_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ACT_W-1:0]   action_o,
  output logic [POS_W-1:0]   position_o,
  output logic [PRICE_W-1:0] best_ask_price_o,
  output logic [QTY_W-1:0]   best_ask_quantity_o,
  output logic [PRICE_W-1:0] best_bid_price_o,
  output logic [QTY_W-1:0]   best_bid_quantity_o
);

  logic               accept;
  logic               load_ok;
  lobl_req_t          req;
  lobl_chain_t        ask_chain, bid_chain, hit;
  logic [PRICE_W-1:0] ask_p, bid_p;
  logic [QTY_W-1:0]   ask_q, bid_q;

  logic               out_valid_q, out_valid_d;
  action_e            act_q, act_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [PRICE_W-1:0] ask_p_q, bid_p_q;
  logic [QTY_W-1:0]   ask_q_q, bid_q_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign req = '{is_load: req_type_i,
                 is_bid:  side_i,
                 index:   CMP_W'(level_index_i),
                 price:   level_price_i,
                 qty:     level_quantity_i};

  lobl_side u_ask (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept && !side_i),
    .req_i        (req),
    .chain_o      (ask_chain),
    .best_price_o (ask_p),
    .best_qty_o   (ask_q)
  );

  lobl_side u_bid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept && side_i),
    .req_i        (req),
    .chain_o      (bid_chain),
    .best_price_o (bid_p),
    .best_qty_o   (bid_q)
  );

  always_comb begin
    hit     = side_i ? bid_chain : ask_chain;
    load_ok = (CMP_W'(level_index_i) < CMP_W'(BOOK_DEPTH));
    act_d   = ACT_NONE;
    pos_d   = '0;
    if (req_type_i) begin
      if (load_ok) begin
        act_d = ACT_LOAD;
        pos_d = POS_W'(level_index_i);
      end
    end else if (hit.found) begin
      act_d = hit.act;
      pos_d = POS_W'(hit.pos);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= act_d;
      pos_q   <= pos_d;
      ask_p_q <= ask_p;
      ask_q_q <= ask_q;
      bid_p_q <= bid_p;
      bid_q_q <= bid_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign action_o            = ACT_W'(act_q);
  assign position_o          = pos_q;
  assign best_ask_price_o    = ask_p_q;
  assign best_ask_quantity_o = ask_q_q;
  assign best_bid_price_o    = bid_p_q;
  assign best_bid_quantity_o = bid_q_q;

endmodule

// ----- rtl/lobl_checker.sv -----
// Port-level checks for the order book top level, attached by bind.
// Depends on lobl_pkg and limit_order_book_level_update.
`timescale 1ns / 1ps

module lobl_checker
  import lobl_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               req_type_i,
  input logic [PRICE_W-1:0] level_price_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [ACT_W-1:0]   action_o,
  input logic [POS_W-1:0]   position_o
);

  // A held result is not overwritten while the receiver stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(action_o)))
    else $error("stalled result changed");

  // Every accepted request shows a result in the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted request produced no result");

  // Input stalls only because a result is waiting.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // An update at price zero is ignored.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !req_type_i && (level_price_i == '0))
      |=> ((action_o == ACT_NONE) && (position_o == '0)))
    else $error("zero-price update not ignored");

endmodule

bind limit_order_book_level_update lobl_checker u_lobl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .req_type_i    (req_type_i),
  .level_price_i (level_price_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .action_o      (action_o),
  .position_o    (position_o)
);
